// File: design/orlr_pkg.sv
// Shared constants, request codes and a pointer helper for the overwriting history ring.
`timescale 1ns / 1ps
package orlr_pkg;
	localparam int RING_DEPTH = 64;
	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W = 7;
	localparam int WORD_W = 64;

	typedef enum logic [1:0] {
		REQ_PUSH = 2'd0,
		REQ_READ = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_STATUS = 2'd3
	} req_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(RING_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction
endpackage

// File: design/overwrite_ring_latest_reader.sv
// Top level: request decode, ring pointers, read sequencer and result stage.
// The first result is registered and appears in the cycle after the word that causes it is accepted.
// Push, clear, status and rejected or empty reads each give a single result and run back to back.
// A read returning n entries strobes once per entry on consecutive cycles; busy stays high until
// the last RAM read is issued, as the single read port of the entry RAM delivers one entry per cycle.
// Reset clears head, fill, push total and the sequencer; the receiver cannot stall.
`timescale 1ns / 1ps
module overwrite_ring_latest_reader (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          req_type,
	input  logic [orlr_pkg::WORD_W-1:0]         entry_in,
	input  logic [orlr_pkg::CNT_W-1:0]          read_count,
	output logic                                strobe,
	output logic [orlr_pkg::WORD_W-1:0]         entry_out,
	output logic                                entry_valid,
	output logic                                last_of_run,
	output logic                                status,
	output logic [orlr_pkg::CNT_W-1:0]          returned_count,
	output logic [orlr_pkg::CNT_W-1:0]          fill_level,
	output logic [orlr_pkg::WORD_W-1:0]         total_pushed
);
	import orlr_pkg::*;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t             state_q;
	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   fill_q;
	logic [WORD_W-1:0]  total_q;
	logic [PTR_W-1:0]   addr_q;
	logic [CNT_W-1:0]   left_q;
	logic               strobe_s1;
	logic               ram_s1;
	logic               last_s1;
	logic               status_s1;
	logic [CNT_W-1:0]   ret_s1;

	logic               accept;
	req_t               req;
	logic               bad_count;
	logic [CNT_W-1:0]   n_sel;
	logic [CNT_W:0]     start_sum;
	logic [PTR_W-1:0]   start_ptr;
	logic               rd_en;
	logic [PTR_W-1:0]   rd_addr;
	logic               wr_en;
	logic [WORD_W-1:0]  rd_data;

	assign busy = (state_q == ST_RUN);
	assign accept = start && !busy;
	assign req = req_t'(req_type);
	assign bad_count = (read_count == '0) || (read_count > CNT_W'(RING_DEPTH));
	assign n_sel = (read_count < fill_q) ? read_count : fill_q;

	always_comb begin
		start_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(RING_DEPTH) - {1'b0, n_sel};
		if (start_sum >= (CNT_W+1)'(RING_DEPTH)) begin
			start_sum = start_sum - (CNT_W+1)'(RING_DEPTH);
		end
		start_ptr = start_sum[PTR_W-1:0];
	end

	assign wr_en = accept && (req == REQ_PUSH);
	assign rd_en = busy || (accept && (req == REQ_READ) && !bad_count && (n_sel != '0));
	assign rd_addr = busy ? addr_q : start_ptr;

	orlr_ram #(
		.WIDTH(WORD_W),
		.DEPTH(RING_DEPTH),
		.ADDR_W(PTR_W)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(head_q),
		.wr_data(entry_in),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			fill_q <= '0;
			total_q <= '0;
			addr_q <= '0;
			left_q <= '0;
			strobe_s1 <= 1'b0;
			ram_s1 <= 1'b0;
			last_s1 <= 1'b0;
			status_s1 <= 1'b0;
			ret_s1 <= '0;
		end else begin
			strobe_s1 <= 1'b0;
			if (accept) begin
				strobe_s1 <= 1'b1;
				ram_s1 <= 1'b0;
				last_s1 <= 1'b1;
				status_s1 <= 1'b0;
				ret_s1 <= '0;
				case (req)
					REQ_PUSH: begin
						head_q <= next_ptr(head_q);
						if (fill_q < CNT_W'(RING_DEPTH)) begin
							fill_q <= fill_q + CNT_W'(1);
						end
						total_q <= total_q + WORD_W'(1);
					end
					REQ_CLEAR: begin
						head_q <= '0;
						fill_q <= '0;
					end
					REQ_READ: begin
						if (bad_count) begin
							status_s1 <= 1'b1;
						end else if (n_sel != '0) begin
							ram_s1 <= 1'b1;
							ret_s1 <= n_sel;
							last_s1 <= (n_sel == CNT_W'(1));
							if (n_sel != CNT_W'(1)) begin
								state_q <= ST_RUN;
								addr_q <= next_ptr(start_ptr);
								left_q <= n_sel - CNT_W'(1);
							end
						end
					end
					REQ_STATUS: begin
					end
					default: begin
					end
				endcase
			end else if (busy) begin
				strobe_s1 <= 1'b1;
				ram_s1 <= 1'b1;
				last_s1 <= (left_q == CNT_W'(1));
				addr_q <= next_ptr(addr_q);
				left_q <= left_q - CNT_W'(1);
				if (left_q == CNT_W'(1)) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	assign strobe = strobe_s1;
	assign entry_out = ram_s1 ? rd_data : '0;
	assign entry_valid = ram_s1;
	assign last_of_run = last_s1;
	assign status = status_s1;
	assign returned_count = ret_s1;
	assign fill_level = fill_q;
	assign total_pushed = total_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(RING_DEPTH))
		else $error("fill count above ring depth");
	a_run_left: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (left_q != '0) && (left_q < fill_q))
		else $error("read sequencer count out of range");
	a_entry_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && entry_valid) |-> $past(rd_en))
		else $error("entry result without a RAM read");
	a_busy_holds_ring: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(head_q) && $stable(fill_q))
		else $error("ring state changed during a read run");
`endif
endmodule

// File: design/orlr_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps
module orlr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// File: test/overwrite_ring_latest_reader_test.sv
// Self-checking testbench for the overwriting history ring with its latest-entries reader.
`timescale 1ns / 1ps
module overwrite_ring_latest_reader_test;
	import orlr_pkg::*;

	localparam int LIMIT_CYCLES = 400000;

	typedef struct {
		logic [WORD_W-1:0] entry;
		logic              valid;
		logic              last;
		logic              stat;
		logic [CNT_W-1:0]  returned;
		logic [CNT_W-1:0]  fill;
		logic [WORD_W-1:0] total;
	} response_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        req_type;
	logic [WORD_W-1:0] entry_in;
	logic [CNT_W-1:0]  read_count;
	logic              strobe;
	logic [WORD_W-1:0] entry_out;
	logic              entry_valid;
	logic              last_of_run;
	logic              status;
	logic [CNT_W-1:0]  returned_count;
	logic [CNT_W-1:0]  fill_level;
	logic [WORD_W-1:0] total_pushed;

	logic [WORD_W-1:0] ring_store [RING_DEPTH];
	int                ring_head;
	int                ring_fill;
	logic [WORD_W-1:0] ring_total;
	response_t         awaited_responses [$];
	int                error_count = 0;
	int                cycle_count = 0;
	int                responses_seen = 0;
	int                kind_count [4];
	bit                use_gaps;

	overwrite_ring_latest_reader uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.entry_in       (entry_in),
		.read_count     (read_count),
		.strobe         (strobe),
		.entry_out      (entry_out),
		.entry_valid    (entry_valid),
		.last_of_run    (last_of_run),
		.status         (status),
		.returned_count (returned_count),
		.fill_level     (fill_level),
		.total_pushed   (total_pushed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: timed out after %0d cycles", $time, cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic response_t summary_response();
		response_t r;
		r = '{default: '0};
		r.last = 1'b1;
		r.fill = CNT_W'(ring_fill);
		r.total = ring_total;
		return r;
	endfunction

	task automatic predict_word(input req_t req, input logic [WORD_W-1:0] word,
			input logic [CNT_W-1:0] want);
		response_t r;
		int n;
		case (req)
			REQ_PUSH: begin
				ring_store[ring_head] = word;
				ring_head = (ring_head == RING_DEPTH - 1) ? 0 : ring_head + 1;
				if (ring_fill < RING_DEPTH) begin
					ring_fill++;
				end
				ring_total++;
				awaited_responses.push_back(summary_response());
			end
			REQ_CLEAR: begin
				ring_head = 0;
				ring_fill = 0;
				awaited_responses.push_back(summary_response());
			end
			REQ_STATUS: begin
				awaited_responses.push_back(summary_response());
			end
			default: begin
				r = summary_response();
				if (want == 0 || want > RING_DEPTH) begin
					r.stat = 1'b1;
					awaited_responses.push_back(r);
				end else begin
					n = (int'(want) < ring_fill) ? int'(want) : ring_fill;
					if (n == 0) begin
						awaited_responses.push_back(r);
					end
					for (int i = 0; i < n; i++) begin
						r.entry = ring_store[(ring_head + RING_DEPTH - n + i) % RING_DEPTH];
						r.valid = 1'b1;
						r.last = (i == n - 1);
						r.returned = CNT_W'(n);
						awaited_responses.push_back(r);
					end
				end
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [WORD_W-1:0] expected,
			input logic [WORD_W-1:0] actual);
		if (expected !== actual) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, expected, actual);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : result_checker
		response_t want_r;
		if (arst_n && strobe) begin
			if (awaited_responses.size() == 0) begin
				$display("%0t: unexpected result, expected none, got entry %h", $time,
					entry_out);
				error_count++;
			end else begin
				want_r = awaited_responses.pop_front();
				check_field("entry_out", want_r.entry, entry_out);
				check_field("entry_valid", WORD_W'(want_r.valid), WORD_W'(entry_valid));
				check_field("last_of_run", WORD_W'(want_r.last), WORD_W'(last_of_run));
				check_field("status", WORD_W'(want_r.stat), WORD_W'(status));
				check_field("returned_count", WORD_W'(want_r.returned),
					WORD_W'(returned_count));
				check_field("fill_level", WORD_W'(want_r.fill), WORD_W'(fill_level));
				check_field("total_pushed", want_r.total, total_pushed);
				responses_seen++;
			end
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end
		if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [WORD_W-1:0] random_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [CNT_W-1:0] pick_read_count();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70 && ring_fill > 0) begin
			return CNT_W'($urandom_range(1, ring_fill));
		end
		if (roll < 85) begin
			return CNT_W'(RING_DEPTH);
		end
		if (roll < 95) begin
			return CNT_W'($urandom_range(1, RING_DEPTH));
		end
		if (roll < 97) begin
			return '0;
		end
		return CNT_W'($urandom_range(RING_DEPTH + 1, 127));
	endfunction

	task automatic send_word(input req_t req, input logic [WORD_W-1:0] word,
			input logic [CNT_W-1:0] want);
		int gap;
		gap = use_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		entry_in <= word;
		read_count <= want;
		do @(posedge clk); while (busy);
		predict_word(req, word, want);
		kind_count[req]++;
	endtask

	task automatic wait_for_drain();
		start <= 1'b0;
		@(posedge clk);
		while (awaited_responses.size() > 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic test_edges_after_reset();
		use_gaps = 1'b1;
		send_word(REQ_STATUS, '1, '1);
		send_word(REQ_READ, '1, 7'd1);
		send_word(REQ_READ, '0, 7'd64);
		send_word(REQ_READ, '0, 7'd0);
		send_word(REQ_READ, '0, 7'd65);
		send_word(REQ_READ, '0, 7'd127);
		send_word(REQ_PUSH, '0, '1);
		send_word(REQ_PUSH, '1, '0);
		send_word(REQ_PUSH, {32{2'b10}}, 7'd64);
		send_word(REQ_PUSH, {32{2'b01}}, 7'd0);
		send_word(REQ_READ, '0, 7'd1);
		send_word(REQ_READ, '1, 7'd4);
		send_word(REQ_READ, '0, 7'd64);
		send_word(REQ_READ, '0, 7'd2);
		send_word(REQ_STATUS, '0, '0);
		send_word(REQ_CLEAR, '1, '1);
		send_word(REQ_READ, '0, 7'd3);
		send_word(REQ_STATUS, '0, 7'd64);
		send_word(REQ_PUSH, 64'h8000_0000_0000_0001, 7'd1);
		send_word(REQ_READ, '0, 7'd1);
		send_word(REQ_CLEAR, '0, '0);
	endtask

	task automatic test_overwrite_wrap();
		use_gaps = 1'b0;
		for (int i = 0; i < 140; i++) begin
			if (i % 17 == 16) begin
				send_word(REQ_READ, random_word(), CNT_W'($urandom_range(1, RING_DEPTH)));
			end else begin
				send_word(REQ_PUSH, random_word(), CNT_W'($urandom_range(0, 127)));
			end
		end
		send_word(REQ_READ, random_word(), 7'd64);
		send_word(REQ_READ, random_word(), 7'd63);
		send_word(REQ_STATUS, random_word(), 7'd0);
		use_gaps = 1'b1;
	endtask

	task automatic test_random_mix(input int words);
		int roll;
		use_gaps = 1'b1;
		for (int i = 0; i < words; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 50) begin
				send_word(REQ_PUSH, random_word(), CNT_W'($urandom_range(0, 127)));
			end else if (roll < 80) begin
				send_word(REQ_READ, random_word(), pick_read_count());
			end else if (roll < 83) begin
				send_word(REQ_CLEAR, random_word(), CNT_W'($urandom_range(0, 127)));
			end else begin
				send_word(REQ_STATUS, random_word(), CNT_W'($urandom_range(0, 127)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_STATUS;
		entry_in = '0;
		read_count = '0;
		use_gaps = 1'b0;
		ring_head = 0;
		ring_fill = 0;
		ring_total = '0;
		foreach (kind_count[k]) kind_count[k] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edges_after_reset();
		wait_for_drain();
		test_overwrite_wrap();
		wait_for_drain();
		test_random_mix(280);
		wait_for_drain();

		$display("Checked %0d results from %0d pushes, %0d reads, %0d clears, %0d status queries.",
			responses_seen, kind_count[REQ_PUSH], kind_count[REQ_READ],
			kind_count[REQ_CLEAR], kind_count[REQ_STATUS]);
		$display("Runs covered empty, invalid and full reads, overwrite wrap and %0d errors.",
			error_count);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
